// ===== rtl/ilt_pkg.sv =====
`default_nettype none

package ilt_pkg;

    // Upper bound on the number of parameters counted on one line.
    localparam int MAX_PARAMS = 15;

    // Saturation point of the parameter counter, limited to what four bits can show.
    localparam logic [3:0] PARAM_CAP =
        4'((MAX_PARAMS < 1) ? 1 : ((MAX_PARAMS < 15) ? MAX_PARAMS : 15));

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [2:0] CMD_DIGITS = 3'd3;
    localparam logic [2:0] CMD_LEN_MAX = 3'd4;

    typedef enum logic [2:0] {
        PH_START,
        PH_PREFIX,
        PH_CMD,
        PH_MIDDLE,
        PH_TRAIL
    } phase_t;

    typedef enum logic [2:0] {
        ROLE_SEP      = 3'd0,
        ROLE_PREFIX   = 3'd1,
        ROLE_COMMAND  = 3'd2,
        ROLE_MIDDLE   = 3'd3,
        ROLE_TRAIL    = 3'd4,
        ROLE_LINE_END = 3'd5
    } role_t;

    typedef struct packed {
        phase_t      phase;
        logic        cr_held;
        logic        line_nonempty;
        logic        in_separator;
        logic [2:0]  cmd_len;
        logic [9:0]  cmd_accum;
        logic        cmd_ok;
        logic [3:0]  param_cnt;
    } tok_state_t;

    typedef struct packed {
        logic [7:0]  byte_val;
        role_t       role;
        logic        token_start;
        logic [3:0]  param_index;
        logic        line_end;
        logic        cmd_numeric;
        logic [9:0]  cmd_value;
        logic [3:0]  param_count;
        logic        last;
    } result_t;

    // All results caused by one input item, at most three.
    typedef struct packed {
        result_t [2:0] res;
        logic [1:0]    count;
    } group_t;

    typedef struct packed {
        tok_state_t st;
        result_t    res;
    } content_t;

endpackage

`default_nettype wire

// ===== rtl/ilt_input_reg.sv =====
`default_nettype none

module ilt_input_reg
    import ilt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] byte_in,
    input  wire logic       message_end,
    input  wire logic       take,
    output logic            item_valid,
    output logic [7:0]      item_byte,
    output logic            item_end
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       end_reg;

    // The register can refill in the same cycle that the core consumes its item.
    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= byte_in;
            end_reg  <= message_end;
        end
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;
    assign item_end   = end_reg;

endmodule

`default_nettype wire

// ===== rtl/ilt_core.sv =====
`default_nettype none

module ilt_core
    import ilt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    input  wire logic [7:0] item_byte,
    input  wire logic       item_end,
    input  wire logic       load_ok,
    output logic            take,
    output group_t          group
);

    tok_state_t state_reg;
    tok_state_t state_next;

    function automatic tok_state_t line_reset(tok_state_t s);
        tok_state_t r;
        r               = s;
        r.phase         = PH_START;
        r.line_nonempty = 1'b0;
        r.in_separator  = 1'b0;
        r.cmd_len       = '0;
        r.cmd_accum     = '0;
        r.cmd_ok        = 1'b1;
        r.param_cnt     = '0;
        return r;
    endfunction

    function automatic result_t byte_result(logic [7:0] c, role_t role, logic start,
                                            logic [3:0] idx);
        result_t r;
        r             = '0;
        r.byte_val    = c;
        r.role        = role;
        r.token_start = start;
        r.param_index = idx;
        return r;
    endfunction

    function automatic tok_state_t command_byte(tok_state_t s, logic [7:0] c);
        tok_state_t  r;
        logic        digit;
        logic [13:0] acc;
        r     = s;
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        // Times ten as two shifted copies; a digit's value is its low nibble.
        acc   = {1'b0, s.cmd_accum, 3'b000} + {3'b000, s.cmd_accum, 1'b0}
              + {10'd0, c[3:0]};
        if (digit && (s.cmd_len < CMD_DIGITS))
        begin
            r.cmd_accum = acc[9:0];
        end
        if (!digit)
        begin
            r.cmd_ok = 1'b0;
        end
        if (s.cmd_len < CMD_LEN_MAX)
        begin
            r.cmd_len = s.cmd_len + 3'd1;
        end
        return r;
    endfunction

    function automatic content_t content(tok_state_t s, logic [7:0] c);
        content_t   o;
        tok_state_t r;
        role_t      role;
        logic       start;
        logic [3:0] idx;
        logic [3:0] cur;
        r               = s;
        role            = ROLE_SEP;
        start           = 1'b0;
        idx             = '0;
        cur             = (s.param_cnt != 4'd0) ? (s.param_cnt - 4'd1) : 4'd0;
        r.line_nonempty = 1'b1;
        if (s.phase == PH_TRAIL)
        begin
            role = ROLE_TRAIL;
            idx  = cur;
        end
        else if (c == CH_SPACE)
        begin
            // Leading spaces rule out a prefix on this line.
            if (s.phase == PH_START)
            begin
                r.phase = PH_PREFIX;
            end
            r.in_separator = 1'b1;
        end
        else if (s.phase == PH_START)
        begin
            start = 1'b1;
            if (c == CH_COLON)
            begin
                r.phase = PH_PREFIX;
                role    = ROLE_PREFIX;
            end
            else
            begin
                r       = command_byte(r, c);
                r.phase = PH_CMD;
                role    = ROLE_COMMAND;
            end
        end
        else if (s.in_separator)
        begin
            r.in_separator = 1'b0;
            start          = 1'b1;
            if (s.phase == PH_PREFIX)
            begin
                r       = command_byte(r, c);
                r.phase = PH_CMD;
                role    = ROLE_COMMAND;
            end
            else
            begin
                // A new parameter opens; the counter saturates at its cap.
                if (s.param_cnt < PARAM_CAP)
                begin
                    r.param_cnt = s.param_cnt + 4'd1;
                end
                idx = r.param_cnt - 4'd1;
                if (c == CH_COLON)
                begin
                    r.phase = PH_TRAIL;
                    role    = ROLE_TRAIL;
                end
                else
                begin
                    r.phase = PH_MIDDLE;
                    role    = ROLE_MIDDLE;
                end
            end
        end
        else if (s.phase == PH_PREFIX)
        begin
            role = ROLE_PREFIX;
        end
        else if (s.phase == PH_CMD)
        begin
            r    = command_byte(r, c);
            role = ROLE_COMMAND;
        end
        else
        begin
            role = ROLE_MIDDLE;
            idx  = cur;
        end
        o.st  = r;
        o.res = byte_result(c, role, start, idx);
        return o;
    endfunction

    tok_state_t    s;
    content_t      co;
    result_t [2:0] res;
    logic [1:0]    n;
    logic          do_close;
    logic          numeric;

    assign take = item_valid && load_ok;

    always_comb
    begin
        s        = state_reg;
        res      = '0;
        n        = 2'd0;
        do_close = 1'b0;
        co       = '0;
        numeric  = 1'b0;

        // A held CR is resolved first, by looking at the byte that follows it.
        if (s.cr_held)
        begin
            s.cr_held = 1'b0;
            if (item_byte == CH_LF)
            begin
                res[0] = byte_result(CH_CR, ROLE_SEP, 1'b0, 4'd0);
            end
            else
            begin
                co     = content(s, CH_CR);
                s      = co.st;
                res[0] = co.res;
            end
            n = 2'd1;
        end

        if (item_byte == CH_LF)
        begin
            res[n]   = byte_result(item_byte, ROLE_SEP, 1'b0, 4'd0);
            n        = n + 2'd1;
            do_close = 1'b1;
        end
        else if ((item_byte == CH_CR) && !item_end)
        begin
            s.cr_held = 1'b1;
        end
        else if (item_byte == CH_CR)
        begin
            res[n]   = byte_result(item_byte, ROLE_SEP, 1'b0, 4'd0);
            n        = n + 2'd1;
            do_close = 1'b1;
        end
        else
        begin
            co       = content(s, item_byte);
            s        = co.st;
            res[n]   = co.res;
            n        = n + 2'd1;
            do_close = item_end;
        end

        if (do_close)
        begin
            if (s.line_nonempty)
            begin
                numeric               = s.cmd_ok && (s.cmd_len == CMD_DIGITS);
                res[n]                = '0;
                res[n].role           = ROLE_LINE_END;
                res[n].line_end       = 1'b1;
                res[n].cmd_numeric    = numeric;
                res[n].cmd_value      = numeric ? s.cmd_accum : 10'd0;
                res[n].param_count    = s.param_cnt;
                n                     = n + 2'd1;
            end
            s = line_reset(s);
        end

        if (n != 2'd0)
        begin
            res[n - 2'd1].last = 1'b1;
        end

        state_next  = s;
        group.res   = res;
        group.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // Start of an empty line, with no CR held.
            state_reg <= line_reset('0);
        end
        else if (take)
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ilt_result_buf.sv =====
`default_nettype none

module ilt_result_buf
    import ilt_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   load,
    input  wire group_t group,
    output logic        load_ok,
    output logic        out_valid,
    input  wire logic   out_ready,
    output result_t     head
);

    group_t     group_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;

    assign out_valid = idx_reg < cnt_reg;

    // Room for a new group once the last waiting result leaves.
    assign load_ok = !out_valid || (out_ready && ((idx_reg + 2'd1) == cnt_reg));

    always_comb
    begin
        case (idx_reg)
            2'd1:    head = group_reg.res[1];
            2'd2:    head = group_reg.res[2];
            default: head = group_reg.res[0];
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load)
        begin
            cnt_next = group.count;
            idx_next = 2'd0;
        end
        else if (out_valid && out_ready)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            group_reg <= group;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/irc_line_tokenizer_top.sv =====
`default_nettype none

// Byte-serial tokenizer for IRC-style message text. Each accepted input item is one
// byte plus a flag marking the message's final byte; each result item tags one byte as
// separator, prefix, command, middle parameter or trailing parameter, and every
// non-empty line closes with a summary item carrying the parameter count and the
// three-digit numeric command, if there is one. A CR is held until the next byte shows
// whether it ends the line, so one input item causes zero to three result items, and
// last_of_run marks the final one of each. Timing: while an accepted item sits in the
// input register, the tokenizer state and all of its results are computed, and they are
// written to the result buffer register once it has room, so an item passes the input
// register and then the result buffer register before its first result is offered. The
// block takes one item per cycle as long as each item causes at most one result and the
// output is ready; an item with several results holds the single output port until all
// are taken, and input items wait behind it. The parameter count saturates at MAX_PARAMS
// (capped at 15) from the package.
module irc_line_tokenizer_top
    import ilt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] byte_in,
    input  wire logic       message_end,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      byte_out,
    output logic [2:0]      role,
    output logic            token_start,
    output logic [3:0]      param_index,
    output logic            line_end,
    output logic            command_is_numeric,
    output logic [9:0]      command_value,
    output logic [3:0]      param_count,
    output logic            last_of_run
);

    logic       item_valid;
    logic [7:0] item_byte;
    logic       item_end;
    logic       take;
    logic       load_ok;
    group_t     group;
    result_t    head;

    // Input register: holds one accepted item until the core takes it.
    ilt_input_reg u_in
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .byte_in     (byte_in),
        .message_end (message_end),
        .take        (take),
        .item_valid  (item_valid),
        .item_byte   (item_byte),
        .item_end    (item_end)
    );

    // Tokenizer state and the combinational result computation.
    ilt_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .item_end   (item_end),
        .load_ok    (load_ok),
        .take       (take),
        .group      (group)
    );

    // Result buffer: holds one item's results and hands them out one per cycle while out_ready is high.
    ilt_result_buf u_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .group     (group),
        .load_ok   (load_ok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign byte_out           = head.byte_val;
    assign role               = head.role;
    assign token_start        = head.token_start;
    assign param_index        = head.param_index;
    assign line_end           = head.line_end;
    assign command_is_numeric = head.cmd_numeric;
    assign command_value      = head.cmd_value;
    assign param_count        = head.param_count;
    assign last_of_run        = head.last;

endmodule

`default_nettype wire

// ===== rtl/ilt_checker.sv =====
`default_nettype none

module ilt_checker
    import ilt_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] byte_out,
    input wire logic [2:0] role,
    input wire logic       token_start,
    input wire logic [3:0] param_index,
    input wire logic       line_end,
    input wire logic       command_is_numeric,
    input wire logic [9:0] command_value,
    input wire logic       last_of_run
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    // The rest of an item's results follow without a gap.
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid)
        else $error("gap inside the results of one item");

    // A line summary carries the line end role, no byte, and closes its run.
    a_summary_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_end |->
            (role == ROLE_LINE_END) && (byte_out == 8'd0) && last_of_run
            && !token_start && (param_index == 4'd0))
        else $error("malformed line summary");

    // The command value is zero unless the command is numeric, and then below 1000; numeric only on a line end.
    a_command_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            (command_is_numeric ? (command_value <= 10'd999) : (command_value == 10'd0))
            && (command_is_numeric ? line_end : 1'b1))
        else $error("command value out of place");

endmodule

bind irc_line_tokenizer_top ilt_checker u_ilt_checker (.*);

`default_nettype wire
